// ===== rtl/mipsx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipsx_pkg
// Shared types and constants for the MIPS-subset instruction executor.
// ----------------------------------------------------------------------------
package mipsx_pkg;

    // Fixed field widths of the item formats.
    localparam int REG_IDX_W  = 5;
    localparam int WORD_W     = 32;
    localparam int LINE_W     = 11;
    localparam int OPCODE_W   = 3;

    // Packed widths of the stream payloads.
    localparam int S_TDATA_W  = 72;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 48;
    localparam int M_TUSER_W  = 1;

    // Instruction codes.
    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD  = 3'd0,
        OP_ADDI = 3'd1,
        OP_SUB  = 3'd2,
        OP_SLT  = 3'd3,
        OP_LW   = 3'd4,
        OP_SW   = 3'd5,
        OP_BEQ  = 3'd6,
        OP_J    = 3'd7
    } op_t;

    // One register file write, as seen by the write port and the bypass.
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] idx;
        logic [WORD_W-1:0]    data;
    } wb_t;

endpackage

// ===== rtl/mips_subset_instruction_executor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor
// Executes one decoded add, addi, sub, slt, lw, sw, beq or j per item
// against a register file and a word data memory, and returns the next line
// number, the register write and a halt flag.
//
// After reset the block zeroes every word of the data memory and holds
// s_axis_tready low while it does so; configuration writes are taken at
// any time. After that it takes one item per cycle for as long as results
// are taken. An accepted item is registered in stage one, where the
// register file read data arrives and the item executes; the data memory
// is accessed as it moves into stage two, which does the register
// write-back while the result is presented.
// Back-to-back dependent items, including a load followed by its use, run
// without stalls through forwarding from the write-back stage. MEM_WORDS
// must be a power of two; memory addresses are the low bits of the address
// register.
// ----------------------------------------------------------------------------
module mips_subset_instruction_executor #(
    parameter int REG_COUNT  = 32,
    parameter int MEM_WORDS  = 1024,
    parameter int LINE_LIMIT = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration: program_length.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mipsx_pkg::LINE_W-1:0]        cfg_data,
    // Input items.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // dest_reg[4:0], src_a[9:5], src_b[14:10], immediate[46:15],
    // target_line[57:47], current_line[68:58], zero pad[71:69]
    input  logic [mipsx_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // opcode[2:0]
    input  logic [mipsx_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    // Result items.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // next_line[10:0], write_value[42:11], halted[43], zero pad[47:44]
    output logic [mipsx_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // write_enable[0]
    output logic [mipsx_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

    localparam int MADDR_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int RI_W    = mipsx_pkg::REG_IDX_W;
    localparam int W       = mipsx_pkg::WORD_W;
    localparam int LW_     = mipsx_pkg::LINE_W;

    // Input field unpacking.
    mipsx_pkg::op_t  in_op;
    logic [RI_W-1:0] in_rd;
    logic [RI_W-1:0] in_ra;
    logic [RI_W-1:0] in_rb;

    assign in_op = mipsx_pkg::op_t'(s_axis_tuser[2:0]);
    assign in_rd = s_axis_tdata[4:0];
    assign in_ra = s_axis_tdata[9:5];
    assign in_rb = s_axis_tdata[14:10];

    // Effective program length, clamped to LINE_LIMIT when written.
    logic [LW_-1:0] limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= (32'(cfg_data) > LINE_LIMIT) ? LW_'(LINE_LIMIT) : cfg_data;
        end
    end

    // Pipeline control.
    logic           s1_valid_reg;
    mipsx_pkg::op_t s1_op_reg;
    logic [RI_W-1:0] s1_rd_reg;
    logic [RI_W-1:0] s1_ra_reg;
    logic [RI_W-1:0] s1_rb_reg;
    logic [W-1:0]    s1_imm_reg;
    logic [LW_-1:0]  s1_target_reg;
    logic [LW_-1:0]  s1_cur_reg;

    logic            s2_valid_reg;
    logic            s2_fresh_reg;
    logic            s2_lw_reg;
    logic            s2_we_reg;
    logic            s2_halt_reg;
    logic [RI_W-1:0] s2_rd_reg;
    logic [W-1:0]    s2_val_reg;
    logic [LW_-1:0]  s2_next_reg;

    logic clr_done;
    logic accept;
    logic s1_adv;
    logic s1_hold;

    assign s1_adv        = s1_valid_reg && (!s2_valid_reg || m_axis_tready);
    assign s1_hold       = s1_valid_reg && !s1_adv;
    assign s_axis_tready = clr_done && (!s1_valid_reg || s1_adv);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Register file read addresses: beq reads dest_reg on port one, sw on
    // port two. A held item re-reads every cycle so its data stays current.
    mipsx_pkg::op_t  sel_op;
    logic [RI_W-1:0] sel_rd;
    logic [RI_W-1:0] sel_ra;
    logic [RI_W-1:0] sel_rb;
    logic [RI_W-1:0] rf_addr1;
    logic [RI_W-1:0] rf_addr2;
    logic [RI_W-1:0] s1_idx1;
    logic [RI_W-1:0] s1_idx2;

    always_comb
    begin
        sel_op   = s1_hold ? s1_op_reg : in_op;
        sel_rd   = s1_hold ? s1_rd_reg : in_rd;
        sel_ra   = s1_hold ? s1_ra_reg : in_ra;
        sel_rb   = s1_hold ? s1_rb_reg : in_rb;
        rf_addr1 = (sel_op == mipsx_pkg::OP_BEQ) ? sel_rd : sel_ra;
        rf_addr2 = (sel_op == mipsx_pkg::OP_SW) ? sel_rd : sel_rb;
        s1_idx1  = (s1_op_reg == mipsx_pkg::OP_BEQ) ? s1_rd_reg : s1_ra_reg;
        s1_idx2  = (s1_op_reg == mipsx_pkg::OP_SW) ? s1_rd_reg : s1_rb_reg;
    end

    // Write-back port and the bypass of last cycle's write.
    mipsx_pkg::wb_t wb_now;
    mipsx_pkg::wb_t wb_last_reg;
    logic [W-1:0]   rf_rdata1;
    logic [W-1:0]   rf_rdata2;
    logic [W-1:0]   dm_rdata;
    logic [W-1:0]   s2_value;

    assign s2_value    = (s2_lw_reg && s2_we_reg) ? dm_rdata : s2_val_reg;
    assign wb_now.en   = s2_valid_reg && s2_fresh_reg && s2_we_reg;
    assign wb_now.idx  = s2_rd_reg;
    assign wb_now.data = s2_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_last_reg <= '0;
        end
        else
        begin
            wb_last_reg <= wb_now;
        end
    end

    mipsx_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .raddr1 (rf_addr1),
        .raddr2 (rf_addr2),
        .rdata1 (rf_rdata1),
        .rdata2 (rf_rdata2),
        .wr     (wb_now)
    );

    // Operand forwarding: this cycle's write first, then last cycle's.
    logic [W-1:0] op1;
    logic [W-1:0] op2;

    always_comb
    begin
        if (wb_now.en && wb_now.idx == s1_idx1)
        begin
            op1 = wb_now.data;
        end
        else if (wb_last_reg.en && wb_last_reg.idx == s1_idx1)
        begin
            op1 = wb_last_reg.data;
        end
        else
        begin
            op1 = rf_rdata1;
        end

        if (wb_now.en && wb_now.idx == s1_idx2)
        begin
            op2 = wb_now.data;
        end
        else if (wb_last_reg.en && wb_last_reg.idx == s1_idx2)
        begin
            op2 = wb_last_reg.data;
        end
        else
        begin
            op2 = rf_rdata2;
        end
    end

    // Execute: result value, register write decision, next line and halt.
    logic [W-1:0]  ex_val;
    logic          ex_writes;
    logic          ex_we;
    logic [LW_:0]  ex_next;
    logic          ex_halt;

    always_comb
    begin
        ex_val  = '0;
        ex_next = {1'b0, s1_cur_reg} + 1'b1;
        case (s1_op_reg)
            mipsx_pkg::OP_ADD:  ex_val = op1 + op2;
            mipsx_pkg::OP_ADDI: ex_val = op1 + s1_imm_reg;
            mipsx_pkg::OP_SUB:  ex_val = op1 - op2;
            mipsx_pkg::OP_SLT:  ex_val = W'($signed(op1) < $signed(op2));
            mipsx_pkg::OP_BEQ:
            begin
                if (op1 == op2)
                begin
                    ex_next = {1'b0, s1_target_reg};
                end
            end
            mipsx_pkg::OP_J:    ex_next = {1'b0, s1_target_reg};
            default:            ex_val = '0;
        endcase
        ex_writes = s1_op_reg inside {mipsx_pkg::OP_ADD, mipsx_pkg::OP_ADDI,
                                      mipsx_pkg::OP_SUB, mipsx_pkg::OP_SLT,
                                      mipsx_pkg::OP_LW};
        ex_we     = ex_writes && (32'(s1_rd_reg) < REG_COUNT);
        if (!ex_we || s1_op_reg == mipsx_pkg::OP_LW)
        begin
            ex_val = '0;
        end
        ex_halt   = (ex_next == '0) || (ex_next > {1'b0, limit_reg});
    end

    // Data memory access for loads and stores as the item leaves stage one.
    logic dm_en;
    logic dm_we;

    assign dm_en = s1_adv && (s1_op_reg == mipsx_pkg::OP_LW ||
                              s1_op_reg == mipsx_pkg::OP_SW);
    assign dm_we = (s1_op_reg == mipsx_pkg::OP_SW);

    mipsx_dmem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dmem (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (dm_en),
        .we       (dm_we),
        .addr     (op1[MADDR_W-1:0]),
        .wdata    (op2),
        .rdata    (dm_rdata),
        .clr_done (clr_done)
    );

    // Stage one: item registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg     <= in_op;
            s1_rd_reg     <= in_rd;
            s1_ra_reg     <= in_ra;
            s1_rb_reg     <= in_rb;
            s1_imm_reg    <= s_axis_tdata[46:15];
            s1_target_reg <= s_axis_tdata[57:47];
            s1_cur_reg    <= s_axis_tdata[68:58];
        end
    end

    // Stage two: result register, which is also the output stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_fresh_reg <= 1'b0;
        end
        else
        begin
            s2_fresh_reg <= s1_adv;
            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_lw_reg   <= (s1_op_reg == mipsx_pkg::OP_LW);
            s2_we_reg   <= ex_we;
            s2_halt_reg <= ex_halt;
            s2_rd_reg   <= s1_rd_reg;
            s2_val_reg  <= ex_val;
            s2_next_reg <= ex_next[LW_-1:0];
        end
    end

    // Output packing.
    assign m_axis_tvalid = s2_valid_reg;
    assign m_axis_tdata  = {4'b0000, s2_halt_reg, s2_value, s2_next_reg};
    assign m_axis_tuser  = s2_we_reg;

    // A register write happens once per item: with no new item entering
    // stage two, the next cycle cannot write again.
    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        wb_now.en && !s1_adv |=> !wb_now.en)
        else $error("register file written twice for one item");

    // A result whose next line is zero must be flagged as halted.
    a_zero_line_halts: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[10:0] == '0 |-> m_axis_tdata[43])
        else $error("next line zero without halt");

    // No item enters while the data memory is being cleared.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_done |-> !s_axis_tready)
        else $error("item accepted during memory clearing pass");

    // A result without a register write carries a zero value.
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[42:11] == '0)
        else $error("nonzero write value without write enable");

endmodule

// ===== rtl/mipsx_regfile.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipsx_regfile
// Register file: synchronous memory with two read ports and one write port,
// read-first on a same-cycle collision. Per-entry valid bits make entries
// that were never written read as zero; indexes at or above REG_COUNT read
// as zero and are never written.
// ----------------------------------------------------------------------------
module mipsx_regfile #(
    parameter int REG_COUNT = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [mipsx_pkg::REG_IDX_W-1:0]     raddr1,
    input  logic [mipsx_pkg::REG_IDX_W-1:0]     raddr2,
    output logic [mipsx_pkg::WORD_W-1:0]        rdata1,
    output logic [mipsx_pkg::WORD_W-1:0]        rdata2,
    input  mipsx_pkg::wb_t                      wr
);

    localparam int RIDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic [mipsx_pkg::WORD_W-1:0] mem [REG_COUNT];
    logic [REG_COUNT-1:0]         vld_reg;
    logic [mipsx_pkg::WORD_W-1:0] q1_reg;
    logic [mipsx_pkg::WORD_W-1:0] q2_reg;
    logic                         hit1_reg;
    logic                         hit2_reg;

    logic [RIDX_W-1:0] a1;
    logic [RIDX_W-1:0] a2;
    logic [RIDX_W-1:0] aw;
    logic              in1;
    logic              in2;
    logic              inw;

    // Index mapping and range checks.
    always_comb
    begin
        a1  = RIDX_W'(raddr1);
        a2  = RIDX_W'(raddr2);
        aw  = RIDX_W'(wr.idx);
        in1 = (32'(raddr1) < REG_COUNT);
        in2 = (32'(raddr2) < REG_COUNT);
        inw = (32'(wr.idx) < REG_COUNT);
    end

    // Storage array: registered reads, single write.
    always_ff @(posedge clk)
    begin
        q1_reg <= mem[a1];
        q2_reg <= mem[a2];
        if (wr.en && inw)
        begin
            mem[aw] <= wr.data;
        end
    end

    // Valid bits and the registered hit flags that go with the read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            hit1_reg <= 1'b0;
            hit2_reg <= 1'b0;
        end
        else
        begin
            hit1_reg <= in1 && vld_reg[a1];
            hit2_reg <= in2 && vld_reg[a2];
            if (wr.en && inw)
            begin
                vld_reg[aw] <= 1'b1;
            end
        end
    end

    assign rdata1 = hit1_reg ? q1_reg : '0;
    assign rdata2 = hit2_reg ? q2_reg : '0;

endmodule

// ===== rtl/mipsx_dmem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipsx_dmem
// Data memory: single-port synchronous word memory with registered read
// data, plus the clearing pass that zeroes every word after reset.
// ----------------------------------------------------------------------------
module mipsx_dmem #(
    parameter int MEM_WORDS = 1024
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            en,
    input  logic                                            we,
    input  logic [((MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1)-1:0] addr,
    input  logic [mipsx_pkg::WORD_W-1:0]                    wdata,
    output logic [mipsx_pkg::WORD_W-1:0]                    rdata,
    output logic                                            clr_done
);

    localparam int MADDR_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam logic [MADDR_W-1:0] LAST_ADDR = MADDR_W'(MEM_WORDS - 1);

    logic [mipsx_pkg::WORD_W-1:0] mem [MEM_WORDS];
    logic [mipsx_pkg::WORD_W-1:0] q_reg;
    logic                         clr_busy_reg;
    logic                         clr_busy_next;
    logic [MADDR_W-1:0]           clr_addr_reg;
    logic [MADDR_W-1:0]           clr_addr_next;

    // Clearing pass sequencing: one word per cycle from address zero up.
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Memory array; the clearing pass owns the port while it runs.
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                q_reg <= mem[addr];
            end
        end
    end

    assign rdata    = q_reg;
    assign clr_done = !clr_busy_reg;

endmodule
